// ----- rtl/scl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_pkg
// Shared types and character codes for the shell command lexer.
// ---------------------------------------------------------------------------
package scl_pkg;

  localparam int unsigned MaxRes = 3;  // results one item can cause

  typedef enum logic [2:0] {
    KIND_CHAR            = 3'd0,
    KIND_TOKEN_END       = 3'd1,
    KIND_LINE_END        = 3'd2,
    KIND_INPUT_END       = 3'd3,
    KIND_INPUT_END_QUOTE = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] token_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       in_quote;
    logic       special_pending;
    logic [7:0] held_symbol;
    logic       word_open;
  } lex_state_t;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChVtab    = 8'h0b;
  localparam logic [7:0] ChFfeed   = 8'h0c;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChGt      = 8'h3e;
  localparam logic [7:0] ChPipe    = 8'h7c;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChLt      = 8'h3c;
  localparam logic [7:0] ChSemi    = 8'h3b;

endpackage

// ----- rtl/scl_lexer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_lexer
// Lexer state register and the single-pass decode of one byte into up to
// three results.
// ---------------------------------------------------------------------------
module scl_lexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                eoi_i,
  output scl_pkg::result_t    list_o [scl_pkg::MaxRes],
  output logic [1:0]          count_o,
  output scl_pkg::lex_state_t state_o
);

  scl_pkg::lex_state_t state_q, state_d;
  scl_pkg::result_t    list [scl_pkg::MaxRes];
  logic [1:0]          n;
  logic                is_blank, is_pair, is_single;

  assign is_blank = (byte_i == scl_pkg::ChSpace) || (byte_i == scl_pkg::ChTab) ||
                    (byte_i == scl_pkg::ChNewline) || (byte_i == scl_pkg::ChVtab) ||
                    (byte_i == scl_pkg::ChFfeed) || (byte_i == scl_pkg::ChCr);
  assign is_pair   = (byte_i == scl_pkg::ChGt) || (byte_i == scl_pkg::ChPipe) ||
                     (byte_i == scl_pkg::ChAmp);
  assign is_single = (byte_i == scl_pkg::ChLt) || (byte_i == scl_pkg::ChSemi);

  always_comb begin
    for (int i = 0; i < scl_pkg::MaxRes; i++) begin
      list[i] = '{kind: scl_pkg::KIND_CHAR, token_byte: 8'h00, last: 1'b0};
    end
    n       = 2'd0;
    state_d = state_q;
    if (eoi_i) begin
      if (state_q.word_open) begin
        list[n].kind = scl_pkg::KIND_TOKEN_END;
        n = n + 2'd1;
      end
      list[n].kind = state_q.in_quote ? scl_pkg::KIND_INPUT_END_QUOTE
                                      : scl_pkg::KIND_INPUT_END;
      n = n + 2'd1;
      state_d = '0;
    end else if (state_q.in_quote) begin
      if (byte_i == scl_pkg::ChQuote) begin
        state_d.in_quote = 1'b0;
      end else begin
        list[n] = '{kind: scl_pkg::KIND_CHAR, token_byte: byte_i, last: 1'b0};
        n = n + 2'd1;
        state_d.word_open = 1'b1;
      end
    end else if (is_blank) begin
      if (state_q.word_open) begin
        list[n].kind = scl_pkg::KIND_TOKEN_END;
        n = n + 2'd1;
      end
      if (byte_i == scl_pkg::ChNewline) begin
        list[n].kind = scl_pkg::KIND_LINE_END;
        n = n + 2'd1;
      end
      state_d.word_open       = 1'b0;
      state_d.special_pending = 1'b0;
      state_d.held_symbol     = 8'h00;
    end else if (byte_i == scl_pkg::ChQuote) begin
      if (state_q.special_pending) begin
        if (state_q.word_open) begin
          list[n].kind = scl_pkg::KIND_TOKEN_END;
          n = n + 2'd1;
        end
        state_d.word_open       = 1'b0;
        state_d.special_pending = 1'b0;
        state_d.held_symbol     = 8'h00;
      end
      state_d.in_quote = 1'b1;
    end else if (is_single) begin
      if (state_q.word_open) begin
        list[n].kind = scl_pkg::KIND_TOKEN_END;
        n = n + 2'd1;
      end
      list[n] = '{kind: scl_pkg::KIND_CHAR, token_byte: byte_i, last: 1'b0};
      n = n + 2'd1;
      list[n].kind = scl_pkg::KIND_TOKEN_END;
      n = n + 2'd1;
      state_d.word_open       = 1'b0;
      state_d.special_pending = 1'b0;
      state_d.held_symbol     = 8'h00;
    end else if (is_pair) begin
      if (state_q.special_pending && (state_q.held_symbol == byte_i)) begin
        // pair complete: second symbol, then close the token
        list[n] = '{kind: scl_pkg::KIND_CHAR, token_byte: byte_i, last: 1'b0};
        n = n + 2'd1;
        list[n].kind = scl_pkg::KIND_TOKEN_END;
        n = n + 2'd1;
        state_d.word_open       = 1'b0;
        state_d.special_pending = 1'b0;
        state_d.held_symbol     = 8'h00;
      end else begin
        if (state_q.word_open) begin
          list[n].kind = scl_pkg::KIND_TOKEN_END;
          n = n + 2'd1;
        end
        list[n] = '{kind: scl_pkg::KIND_CHAR, token_byte: byte_i, last: 1'b0};
        n = n + 2'd1;
        state_d.word_open       = 1'b1;
        state_d.special_pending = 1'b1;
        state_d.held_symbol     = byte_i;
      end
    end else begin
      if (state_q.special_pending) begin
        if (state_q.word_open) begin
          list[n].kind = scl_pkg::KIND_TOKEN_END;
          n = n + 2'd1;
        end
        state_d.special_pending = 1'b0;
        state_d.held_symbol     = 8'h00;
      end
      list[n] = '{kind: scl_pkg::KIND_CHAR, token_byte: byte_i, last: 1'b0};
      n = n + 2'd1;
      state_d.word_open = 1'b1;
    end
    if (n != 2'd0) begin
      list[n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  assign list_o  = list;
  assign count_o = n;
  assign state_o = state_q;

endmodule

// ----- rtl/scl_resq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_resq
// Result list register drained one entry a cycle, unless stalled, into an output register.
// ---------------------------------------------------------------------------
module scl_resq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  scl_pkg::result_t list_i [scl_pkg::MaxRes],
  input  logic [1:0]       count_i,
  output logic             ready_o,
  output logic             valid_o,
  output scl_pkg::result_t data_o,
  input  logic             ready_i
);

  scl_pkg::result_t list_q [scl_pkg::MaxRes];
  logic [1:0]       cnt_q;
  logic             out_valid_q;
  scl_pkg::result_t out_q;
  logic             move;

  // head entry moves on when the output register is free or being taken
  assign move    = (cnt_q != 2'd0) && (!out_valid_q || ready_i);
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= count_i;
      end else if (move) begin
        cnt_q <= cnt_q - 2'd1;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= list_i;
    end else if (move) begin
      for (int i = 0; i < scl_pkg::MaxRes - 1; i++) begin
        list_q[i] <= list_q[i + 1];
      end
    end
    if (move) begin
      out_q <= list_q[0];
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ----- rtl/shell_command_lexer_top.sv -----
`timescale 1ns / 1ps
// An accepted item's results go to the list register, then to the output register.
// Throughput: one item per cycle while each item causes at most one result and the
//   output is taken; an item causing more results (up to 3) holds off the next item.
// The output register drains the result list register one entry per cycle unless stalled.
// Reset (rst_ni low, asynchronous): lexer state cleared, no results pending.
// ---------------------------------------------------------------------------
// shell_command_lexer_top
// Streaming shell command-line tokenizer: bytes in, token characters and
// token, line and input end marks out.
// ---------------------------------------------------------------------------
module shell_command_lexer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input item
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  logic       s_axis_tuser_i,   // [0] end_of_input
  // result item
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] token_byte
  output logic [2:0] m_axis_tuser_o,   // [2:0] kind
  output logic       m_axis_tlast_o    // last result of the item
);

  logic                s_acc;
  scl_pkg::result_t    list [scl_pkg::MaxRes];
  logic [1:0]          count;
  scl_pkg::lex_state_t lex_st;
  scl_pkg::result_t    out_res;

  // An item is taken whenever the list register is empty or is handing on
  // its final entry this cycle; the lexer state advances on the same edge.
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  scl_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_acc),
    .byte_i   (s_axis_tdata_i),
    .eoi_i    (s_axis_tuser_i),
    .list_o   (list),
    .count_o  (count),
    .state_o  (lex_st)
  );

  // Items with no result (a quote, a bare blank) load an empty list.
  scl_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_acc),
    .list_i  (list),
    .count_i (count),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .data_o  (out_res),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = out_res.token_byte;
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.last;

  // End of input always yields at least the input-end mark.
  a_eoi_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser_i) |-> (count != 2'd0))
    else $error("end of input decoded to no result");

  // End of input returns the lexer to a fresh start.
  a_eoi_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser_i) |=> (!lex_st.in_quote && !lex_st.word_open &&
                                   !lex_st.special_pending))
    else $error("lexer state not cleared after end of input");

  // A held symbol has always been emitted, so its word is open.
  a_held_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lex_st.special_pending |-> lex_st.word_open)
    else $error("symbol held without an open word");

  // Character results carry a byte, marks carry zero.
  a_mark_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_res.kind != scl_pkg::KIND_CHAR)) |->
      (m_axis_tdata_o == 8'h00))
    else $error("mark result with non-zero byte");

endmodule
